/* hdl/ffp_pkg.sv */
// ----------------------------------------------------------------------------
// ffp_pkg
// Types, constants and helpers shared by the FASTA/FASTQ record parser.
// ----------------------------------------------------------------------------
package ffp_pkg;

   // Sequence length counter width; record_length saturates at 32 bits.
   localparam int LENGTH_BITS = 32;
   localparam int RECORD_BITS = 32;
   localparam int LEN_EXT_W   = (LENGTH_BITS > RECORD_BITS) ? LENGTH_BITS : RECORD_BITS;

   // Queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Configuration register indexes
   localparam logic [1:0] CSR_FORMAT_MODE    = 2'd0;
   localparam logic [1:0] CSR_QUALITY_OFFSET = 2'd1;
   localparam logic [1:0] CSR_QUALITY_MAX    = 2'd2;

   localparam logic       FORMAT_RESET = 1'b0;
   localparam logic [7:0] QOFFSET_RESET = 8'h21;   // '!'
   localparam logic [7:0] QMAX_RESET    = 8'd100;

   // Characters
   localparam logic [7:0] CHAR_FASTA_HDR = 8'h3E;  // '>'
   localparam logic [7:0] CHAR_FASTQ_HDR = 8'h40;  // '@'
   localparam logic [7:0] CHAR_PLUS      = 8'h2B;  // '+'
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;

   localparam logic [7:0] ERR_HEADER = 8'd0;
   localparam logic [7:0] ERR_COUNT  = 8'd1;

   typedef enum logic [2:0] {
      KIND_NAME = 3'd0,
      KIND_BASE = 3'd1,
      KIND_QUAL = 3'd2,
      KIND_END  = 3'd3,
      KIND_ERR  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      PH_WAIT,
      PH_NAME,
      PH_SEQ,
      PH_PLUS,
      PH_QUAL,
      PH_TAIL
   } phase_type;

   // One result on its way from front to back; QUAL items carry the raw byte
   typedef struct packed {
      kind_type               kind;
      logic [7:0]             value;
      logic [RECORD_BITS-1:0] length;
   } item_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic [RECORD_BITS-1:0] sat_len(input logic [LENGTH_BITS-1:0] cnt);
      logic [LEN_EXT_W-1:0] ext;
      ext = LEN_EXT_W'(cnt);
      if (ext > LEN_EXT_W'({RECORD_BITS{1'b1}})) begin
         return {RECORD_BITS{1'b1}};
      end
      return ext[RECORD_BITS-1:0];
   endfunction

endpackage

/* hdl/fasta_fastq_record_parser.sv */
// ----------------------------------------------------------------------------
// fasta_fastq_record_parser
// FASTA/FASTQ text parser, one byte in per cycle while the queue has room, tagged results out.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one file byte per beat in req_tdata; req_tlast marks end of file
//            (the byte is then ignored) and returns the parser to its start.
//   rsp_*  : one result per beat; rsp_tuser is the kind (name char, base,
//            quality, record end, error), rsp_tdata holds value and length.
//            Each byte gives at most one result, so rsp_tlast is always set.
//   csr_*  : format mode, quality offset and quality clamp; write only while
//            the block is idle.
// Throughput is one byte per cycle while the queue has room; the classifier
// updates its record state at the edge that takes each byte. A result is
// queued at the edge that takes its byte and moves from the queue head into
// the output register, which drives rsp_tvalid, once that register is free.
// When the receiver stalls the output register holds its beat, the queue fills
// behind it, and req_tready drops once all four queue entries are occupied.
// Reset (synchronous) empties the queue and output register, clears the parser
// state and restores the register defaults.
// ----------------------------------------------------------------------------
module fasta_fastq_record_parser (
   input  logic        clock,
   input  logic        reset,
   // request: [7:0] data_byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   // response tdata: [7:0] result_value, [39:8] record_length
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // response tuser: [2:0] result_kind
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import ffp_pkg::*;

   logic       format_ff;
   logic [7:0] qoffset_ff;
   logic [7:0] qmax_ff;

   logic     accept;
   logic     push;
   item_type push_item;
   logic     full;
   logic     pop;
   logic     head_valid;
   item_type head_item;
   item_type out_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff  <= FORMAT_RESET;
         qoffset_ff <= QOFFSET_RESET;
         qmax_ff    <= QMAX_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FORMAT_MODE:    format_ff  <= csr_wdata[0];
            CSR_QUALITY_OFFSET: qoffset_ff <= csr_wdata;
            CSR_QUALITY_MAX:    qmax_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   ffp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_tdata),
      .end_of_stream (req_tlast),
      .format_mode   (format_ff),
      .push          (push),
      .push_item     (push_item)
   );

   ffp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   ffp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .quality_offset (qoffset_ff),
      .quality_max    (qmax_ff),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .pop            (pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_item       (out_item)
   );

   assign rsp_tdata = {out_item.length, out_item.value};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = 1'b1;

endmodule

/* hdl/ffp_front.sv */
// ----------------------------------------------------------------------------
// ffp_front
// Byte classifier: tracks the record phase and queues at most one result per
// accepted byte.
// ----------------------------------------------------------------------------
module ffp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             end_of_stream,
   input  logic             format_mode,
   output logic             push,
   output ffp_pkg::item_type push_item
);
   import ffp_pkg::*;

   phase_type              phase_ff, phase_in;
   logic                   line_start_ff, line_start_in;
   logic                   name_done_ff, name_done_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic [LENGTH_BITS-1:0] qrem_ff, qrem_in;
   logic                   err_ff, err_in;

   logic fastq;
   logic nl;
   logic ws;

   assign fastq = format_mode;
   assign nl    = (data_byte == CHAR_LF);
   assign ws    = is_ws(data_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT;
         line_start_ff <= 1'b1;
         name_done_ff  <= 1'b0;
         count_ff      <= '0;
         qrem_ff       <= '0;
         err_ff        <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         line_start_ff <= line_start_in;
         name_done_ff  <= name_done_in;
         count_ff      <= count_in;
         qrem_ff       <= qrem_in;
         err_ff        <= err_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      line_start_in = line_start_ff;
      name_done_in  = name_done_ff;
      count_in      = count_ff;
      qrem_in       = qrem_ff;
      err_in        = err_ff;
      push          = 1'b0;
      push_item     = '{kind: KIND_NAME, value: data_byte, length: '0};

      if (accept) begin
         if (end_of_stream) begin
            if (!err_ff) begin
               unique case (phase_ff)
                  PH_NAME, PH_SEQ, PH_TAIL: begin
                     push      = 1'b1;
                     push_item = '{kind: KIND_END, value: 8'd0, length: sat_len(count_ff)};
                  end
                  PH_PLUS, PH_QUAL: begin
                     push = 1'b1;
                     if (qrem_ff != '0) begin
                        push_item = '{kind: KIND_ERR, value: ERR_COUNT, length: '0};
                     end else begin
                        push_item = '{kind: KIND_END, value: 8'd0,
                                      length: sat_len(count_ff)};
                     end
                  end
                  default: ;
               endcase
            end
            // end of file returns everything to its reset state
            phase_in      = PH_WAIT;
            line_start_in = 1'b1;
            name_done_in  = 1'b0;
            count_in      = '0;
            qrem_in       = '0;
            err_in        = 1'b0;
         end else if (!err_ff) begin
            unique case (phase_ff)
               PH_WAIT: begin
                  if (fastq && nl) begin
                     phase_in = PH_WAIT;
                  end else if (data_byte == (fastq ? CHAR_FASTQ_HDR : CHAR_FASTA_HDR)) begin
                     phase_in     = PH_NAME;
                     name_done_in = 1'b0;
                     count_in     = '0;
                  end else begin
                     push      = 1'b1;
                     push_item = '{kind: KIND_ERR, value: ERR_HEADER, length: '0};
                     err_in    = 1'b1;
                  end
               end
               PH_NAME: begin
                  if (nl) begin
                     phase_in      = PH_SEQ;
                     line_start_in = 1'b1;
                  end else if (!name_done_ff) begin
                     if (ws) begin
                        name_done_in = 1'b1;
                     end else begin
                        push = 1'b1;
                     end
                  end
               end
               PH_SEQ: begin
                  if (line_start_ff && !fastq && data_byte == CHAR_FASTA_HDR) begin
                     push          = 1'b1;
                     push_item     = '{kind: KIND_END, value: 8'd0,
                                       length: sat_len(count_ff)};
                     phase_in      = PH_NAME;
                     name_done_in  = 1'b0;
                     count_in      = '0;
                     line_start_in = 1'b0;
                  end else if (line_start_ff && fastq && data_byte == CHAR_PLUS) begin
                     phase_in      = PH_PLUS;
                     qrem_in       = count_ff;
                     line_start_in = 1'b0;
                  end else begin
                     line_start_in = nl;
                     if (!ws) begin
                        if (count_ff != '1) begin
                           count_in = count_ff + 1'b1;
                        end
                        push      = 1'b1;
                        push_item = '{kind: KIND_BASE, value: data_byte, length: '0};
                     end
                  end
               end
               PH_PLUS: begin
                  if (nl) begin
                     if (qrem_ff == '0) begin
                        push          = 1'b1;
                        push_item     = '{kind: KIND_END, value: 8'd0,
                                          length: sat_len(count_ff)};
                        phase_in      = PH_WAIT;
                        line_start_in = 1'b1;
                     end else begin
                        phase_in = PH_QUAL;
                     end
                  end
               end
               PH_QUAL: begin
                  if (!ws) begin
                     push      = 1'b1;
                     push_item = '{kind: KIND_QUAL, value: data_byte, length: '0};
                     qrem_in   = qrem_ff - 1'b1;
                     if (qrem_ff == LENGTH_BITS'(1)) begin
                        phase_in = PH_TAIL;
                     end
                  end
               end
               PH_TAIL: begin
                  if (nl) begin
                     push          = 1'b1;
                     push_item     = '{kind: KIND_END, value: 8'd0,
                                       length: sat_len(count_ff)};
                     phase_in      = PH_WAIT;
                     line_start_in = 1'b1;
                  end else if (!ws) begin
                     push      = 1'b1;
                     push_item = '{kind: KIND_ERR, value: ERR_COUNT, length: '0};
                     err_in    = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // a held error swallows every byte but the end of file
   a_err_silent: assert property (@(posedge clock) disable iff (reset)
      (err_ff && accept && !end_of_stream) |-> !push)
      else $error("ffp_front: result queued while an error is held");

   // the quality phase is only reached with qualities still owed
   a_qual_owed: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_QUAL) |-> (qrem_ff != '0))
      else $error("ffp_front: quality phase with nothing owed");

   // end of file always leaves the parser clear
   a_eos_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_stream) |=> (phase_ff == PH_WAIT && !err_ff && count_ff == '0))
      else $error("ffp_front: state not cleared after end of file");

endmodule

/* hdl/ffp_queue.sv */
// ----------------------------------------------------------------------------
// ffp_queue
// Short FIFO of pending results between the classifier and the output stage.
// ----------------------------------------------------------------------------
module ffp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ffp_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output ffp_pkg::item_type head_item
);
   import ffp_pkg::*;

   item_type          store_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("ffp_queue: push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("ffp_queue: pop from an empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("ffp_queue: occupancy beyond depth");

endmodule

/* hdl/ffp_back.sv */
// ----------------------------------------------------------------------------
// ffp_back
// Output stage: converts quality bytes and holds one result for the receiver.
// ----------------------------------------------------------------------------
module ffp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        quality_offset,
   input  logic [7:0]        quality_max,
   input  logic              head_valid,
   input  ffp_pkg::item_type head_item,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output ffp_pkg::item_type out_item
);
   import ffp_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     load;
   logic [8:0] diff;
   logic [7:0] qual;

   assign load = !valid_ff || out_ready;
   assign pop  = head_valid && load;

   always_comb begin
      diff = {1'b0, head_item.value} - {1'b0, quality_offset};
      qual = diff[8] ? 8'd0 : diff[7:0];
      if (qual > quality_max) begin
         qual = quality_max;
      end
      item_in = head_item;
      if (head_item.kind == KIND_QUAL) begin
         item_in.value = qual;
      end
      valid_in = pop ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // converted qualities never exceed the clamp
   a_qual_clamp: assert property (@(posedge clock) disable iff (reset)
      (pop && head_item.kind == KIND_QUAL) |=> (item_ff.value <= quality_max))
      else $error("ffp_back: quality above clamp");

   // only record ends carry a length
   a_len_end_only: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && item_ff.kind != KIND_END) |-> (item_ff.length == '0))
      else $error("ffp_back: length on a result that is not a record end");

   // a waiting result is not replaced
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |-> !pop)
      else $error("ffp_back: output overwritten while stalled");

endmodule
